>>> hw/rtl/two_level_cache_tag_engine_defines.svh
// Assertion macros for the cache tag engine
`ifndef TWO_LEVEL_CACHE_TAG_ENGINE_DEFINES_SVH
`define TWO_LEVEL_CACHE_TAG_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define TCE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define TCE_ASSERT(label, clk, rst_n, prop, msg)
`define TCE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hw/rtl/tce_pkg.sv
package tce_pkg;
	localparam int L1_SET_BITS_MAX_D = 6;
	localparam int L2_SET_BITS_MAX_D = 8;
	localparam int WAYS_MAX_D = 8;
	localparam int ADDR_BITS_D = 32;
	localparam int BLOCK_BITS_TOP = 8;

	typedef enum logic [1:0] {
		MODE_FETCH  = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_STORE  = 2'd2,
		MODE_MODIFY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_L1_SET_BITS   = 3'd0,
		REG_L1_WAYS       = 3'd1,
		REG_L1_BLOCK_BITS = 3'd2,
		REG_L2_SET_BITS   = 3'd3,
		REG_L2_WAYS       = 3'd4,
		REG_L2_BLOCK_BITS = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} back_state_t;

	// push and full controls of the queue inside the front end
	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;
endpackage

>>> hw/rtl/tce_ram.sv
module tce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/tce_front.sv
module tce_front
	import tce_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  logic [31:0]          address,
	input  logic                 pop,
	output logic                 busy,
	output logic                 q_valid,
	output logic [1:0]           q_mode,
	output logic [ADDR_BITS-1:0] q_addr
);
	localparam int DEPTH = 2;
	localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

	logic [1:0]           mode_q [DEPTH];
	logic [ADDR_BITS-1:0] addr_q [DEPTH];
	logic                 wp_q, rp_q;
	logic [1:0]           cnt_q;
	q_ctl_t               ctl;
	logic [ADDR_BITS-1:0] addr_in;

	always_comb begin
		addr_in = '0;
		addr_in[AW-1:0] = address[AW-1:0];
	end

	assign ctl.full = (cnt_q == 2'(DEPTH));
	assign ctl.push = start && !busy;
	assign busy     = ctl.full;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_mode   = mode_q[rp_q];
	assign q_addr   = addr_q[rp_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mode_q[wp_q] <= mode;
			addr_q[wp_q] <= addr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (ctl.push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(ctl.push) - 2'(pop);
		end
	end
endmodule

>>> hw/rtl/tce_level.sv
module tce_level
	import tce_pkg::*;
#(
	parameter int SET_BITS = 6,
	parameter int WAYS     = 8,
	parameter int BANKS    = 2,
	parameter int TAG_W    = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [((BANKS > 1) ? $clog2(BANKS) : 1)-1:0] bank,
	input  logic [SET_BITS-1:0]                          set_idx,
	input  logic [TAG_W-1:0]                             tag,
	input  logic [3:0]                                   ways,
	input  logic                                         upd,
	input  logic                                         do_fill,
	output logic                                         ready,
	output logic                                         hit,
	output logic                                         evict
);
	localparam int SETS = 1 << SET_BITS;
	localparam int ROWS = BANKS * SETS;
	localparam int RA   = $clog2(ROWS);
	localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RW   = WAYS + WW;

	logic [TAG_W-1:0] rtag [WAYS];
	logic [RA-1:0]    addr, clr_q, st_waddr;
	logic             clearing_q, st_we;
	logic [RW-1:0]    st_rdata, st_wdata;
	logic [WAYS-1:0]  vraw, vrow, inway, wsel, freeway;
	logic [WW-1:0]    oraw, victim, onext;
	logic             anyfree;

	assign addr = RA'({bank, set_idx});

	for (genvar w = 0; w < WAYS; w++) begin : g_way
		tce_ram #(.WIDTH(TAG_W), .DEPTH(ROWS)) u_tags (
			.clk(clk), .we(upd && do_fill && wsel[w]), .waddr(addr),
			.wdata(tag), .raddr(addr), .rdata(rtag[w])
		);
		assign inway[w] = (4'(w) < ways);
	end

	// per-set row: FIFO pointer above the valid bits
	tce_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_state (
		.clk(clk), .we(st_we), .waddr(st_waddr),
		.wdata(st_wdata), .raddr(addr), .rdata(st_rdata)
	);

	assign {oraw, vraw} = st_rdata;
	assign vrow = vraw & inway;

	always_comb begin
		hit = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (vrow[w] && rtag[w] == tag) begin
				hit = 1'b1;
			end
		end
		freeway = inway & ~vrow;
		freeway = freeway & (~freeway + 1'b1);
		anyfree = |freeway;
		victim  = (4'(oraw) < ways) ? oraw : '0;
		wsel    = anyfree ? freeway : (WAYS'(1) << victim);
		evict   = !anyfree;
		onext   = anyfree ? oraw : ((4'(victim) + 4'd1 == ways) ? '0 : victim + WW'(1));
	end

	// clear every row once after reset
	assign st_we    = clearing_q || (upd && do_fill);
	assign st_waddr = clearing_q ? clr_q : addr;
	assign st_wdata = clearing_q ? '0 : {onext, vraw | wsel};
	assign ready    = !clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + RA'(1);
			if (clr_q == RA'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end
endmodule

>>> hw/rtl/tce_back.sv
`include "two_level_cache_tag_engine_defines.svh"
module tce_back
	import tce_pkg::*;
#(
	parameter int L1_SET_BITS_MAX = L1_SET_BITS_MAX_D,
	parameter int L2_SET_BITS_MAX = L2_SET_BITS_MAX_D,
	parameter int WAYS_MAX        = WAYS_MAX_D,
	parameter int ADDR_BITS       = ADDR_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  logic [1:0]           q_mode,
	input  logic [ADDR_BITS-1:0] q_addr,
	input  logic [2:0]           s1_cfg,
	input  logic [3:0]           e1_cfg,
	input  logic [3:0]           b1_cfg,
	input  logic [3:0]           s2_cfg,
	input  logic [3:0]           e2_cfg,
	input  logic [3:0]           b2_cfg,
	output logic                 pop,
	output logic                 done,
	output logic                 l1_hit,
	output logic                 l2_hit,
	output logic                 l1_evicted,
	output logic                 l2_evicted
);
	localparam int S1W = (L1_SET_BITS_MAX > 0) ? L1_SET_BITS_MAX : 1;
	localparam int S2W = (L2_SET_BITS_MAX > 0) ? L2_SET_BITS_MAX : 1;

	back_state_t state_q, state_d;
	logic [1:0]           mode_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [3:0] s1, s2, b1, b2, e1, e2;
	logic [S1W-1:0] set1;
	logic [S2W-1:0] set2;
	logic [ADDR_BITS-1:0] tag1, tag2;
	logic h1, h2, v1, v2, fill, upd;
	logic l1_rdy, l2_rdy;
	logic done_q, l1h_q, l2h_q, l1e_q, l2e_q;

	always_comb begin
		s1 = ({1'b0, s1_cfg} > 4'(L1_SET_BITS_MAX)) ? 4'(L1_SET_BITS_MAX) : {1'b0, s1_cfg};
		s2 = (s2_cfg > 4'(L2_SET_BITS_MAX)) ? 4'(L2_SET_BITS_MAX) : s2_cfg;
		b1 = (b1_cfg > 4'(BLOCK_BITS_TOP)) ? 4'(BLOCK_BITS_TOP) : b1_cfg;
		b2 = (b2_cfg > 4'(BLOCK_BITS_TOP)) ? 4'(BLOCK_BITS_TOP) : b2_cfg;
		e1 = (e1_cfg == 4'd0) ? 4'd1 :
			({1'b0, e1_cfg} > 5'(WAYS_MAX)) ? 4'(WAYS_MAX) : e1_cfg;
		e2 = (e2_cfg == 4'd0) ? 4'd1 :
			({1'b0, e2_cfg} > 5'(WAYS_MAX)) ? 4'(WAYS_MAX) : e2_cfg;
		set1 = S1W'((addr_q >> b1) & ~({ADDR_BITS{1'b1}} << s1));
		set2 = S2W'((addr_q >> b2) & ~({ADDR_BITS{1'b1}} << s2));
		tag1 = addr_q >> (b1 + s1);
		tag2 = addr_q >> (5'(b2) + 5'(s2));
		if (L1_SET_BITS_MAX == 0) set1 = '0;
		if (L2_SET_BITS_MAX == 0) set2 = '0;
	end

	assign fill = (mode_q != MODE_STORE);
	assign upd  = (state_q == ST_UPDATE);

	tce_level #(.SET_BITS(S1W), .WAYS(WAYS_MAX), .BANKS(2), .TAG_W(ADDR_BITS)) u_l1 (
		.clk(clk), .arst_n(arst_n), .bank(mode_q != MODE_FETCH),
		.set_idx(set1), .tag(tag1), .ways(e1), .upd(upd),
		.do_fill(fill && !h1), .ready(l1_rdy), .hit(h1), .evict(v1)
	);

	tce_level #(.SET_BITS(S2W), .WAYS(WAYS_MAX), .BANKS(1), .TAG_W(ADDR_BITS)) u_l2 (
		.clk(clk), .arst_n(arst_n), .bank(1'b0),
		.set_idx(set2), .tag(tag2), .ways(e2), .upd(upd),
		.do_fill(fill && !h2), .ready(l2_rdy), .hit(h2), .evict(v2)
	);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && l1_rdy && l2_rdy) begin
					pop     = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_q <= q_mode;
			addr_q <= q_addr;
		end
		if (upd) begin
			l1h_q <= h1;
			l2h_q <= h2;
			l1e_q <= fill && !h1 && v1;
			l2e_q <= fill && !h2 && v2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= upd;
		end
	end

	assign done       = done_q;
	assign l1_hit     = l1h_q;
	assign l2_hit     = l2h_q;
	assign l1_evicted = l1e_q;
	assign l2_evicted = l2e_q;

	`TCE_ASSERT(a_pop_idle, clk, arst_n, pop |-> state_q == ST_IDLE, "pop outside idle")
	`TCE_ASSERT_NEXT(a_read_upd, clk, arst_n, state_q == ST_READ, state_q == ST_UPDATE,
		"read not followed by update")
	`TCE_ASSERT_NEXT(a_done, clk, arst_n, upd, done, "update without result")
	`TCE_ASSERT(a_store_quiet, clk, arst_n,
		(done && mode_q == MODE_STORE) |-> !(l1_evicted || l2_evicted), "store evicted")
endmodule

>>> hw/rtl/two_level_cache_tag_engine.sv
// Two-level cache tag engine: split L1 (fetch / data) and unified L2 tags, FIFO replace.
// Input: pulse start with mode and address; the item is taken when busy is low.
// A two-entry queue holds items, so busy rises only when that queue is full.
// Result: done is high for one cycle with l1_hit, l2_hit, l1_evicted, l2_evicted.
// An accepted item waits in the queue, then goes through the READ and UPDATE states;
// done is registered from UPDATE. The back end takes one item at a time: queue pop,
// tag and valid RAM read, then the way compare and the fill write in UPDATE.
// Configuration: cfg_we, cfg_index, cfg_data write one geometry register per cycle;
// write only while no item is in flight.
// Reset starts a clearing pass over every row of the valid and FIFO pointer RAMs,
// in L1 and L2 in parallel. Items wait in the queue meanwhile.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "two_level_cache_tag_engine_defines.svh"
module two_level_cache_tag_engine
	import tce_pkg::*;
#(
	parameter int L1_SET_BITS_MAX = L1_SET_BITS_MAX_D,
	parameter int L2_SET_BITS_MAX = L2_SET_BITS_MAX_D,
	parameter int WAYS_MAX        = WAYS_MAX_D,
	parameter int ADDR_BITS       = ADDR_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] address,
	output logic        done,
	output logic        l1_hit,
	output logic        l2_hit,
	output logic        l1_evicted,
	output logic        l2_evicted,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	logic [2:0] s1_q;
	logic [3:0] e1_q, b1_q, s2_q, e2_q, b2_q;
	logic pop, q_valid;
	logic [1:0] q_mode;
	logic [ADDR_BITS-1:0] q_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0; e1_q <= 4'd1; b1_q <= '0;
			s2_q <= '0; e2_q <= 4'd1; b2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_L1_SET_BITS:   s1_q <= cfg_data[2:0];
				REG_L1_WAYS:       e1_q <= cfg_data;
				REG_L1_BLOCK_BITS: b1_q <= cfg_data;
				REG_L2_SET_BITS:   s2_q <= cfg_data;
				REG_L2_WAYS:       e2_q <= cfg_data;
				REG_L2_BLOCK_BITS: b2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tce_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode), .address(address),
		.pop(pop), .busy(busy), .q_valid(q_valid), .q_mode(q_mode), .q_addr(q_addr)
	);

	tce_back #(
		.L1_SET_BITS_MAX(L1_SET_BITS_MAX), .L2_SET_BITS_MAX(L2_SET_BITS_MAX),
		.WAYS_MAX(WAYS_MAX), .ADDR_BITS(ADDR_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_mode(q_mode), .q_addr(q_addr),
		.s1_cfg(s1_q), .e1_cfg(e1_q), .b1_cfg(b1_q),
		.s2_cfg(s2_q), .e2_cfg(e2_q), .b2_cfg(b2_q),
		.pop(pop), .done(done), .l1_hit(l1_hit), .l2_hit(l2_hit),
		.l1_evicted(l1_evicted), .l2_evicted(l2_evicted)
	);

	`TCE_ASSERT(a_pop_valid, clk, arst_n, pop |-> q_valid, "pop of empty queue")
	`TCE_ASSERT_NEXT(a_busy_hold, clk, arst_n, busy && !pop, busy, "busy dropped without pop")
	`TCE_ASSERT(a_no_evict_on_hit, clk, arst_n, (done && l1_hit) |-> !l1_evicted,
		"L1 hit with eviction")
endmodule

>>> sim/two_level_cache_tag_engine_checker.sv
module two_level_cache_tag_engine_checker
	import tce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] address,
	input  logic        done,
	input  logic        l1_hit,
	input  logic        l2_hit,
	input  logic        l1_evicted,
	input  logic        l2_evicted,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output int          pending,
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int L1_LINES = (1 << L1_SET_BITS_MAX_D) * WAYS_MAX_D;
	localparam int L2_LINES = (1 << L2_SET_BITS_MAX_D) * WAYS_MAX_D;

	typedef struct packed {
		logic l1_hit;
		logic l2_hit;
		logic l1_evicted;
		logic l2_evicted;
	} outcome_t;

	logic [2:0] l1_sets_r;
	logic [3:0] l1_ways_r, l1_blk_r, l2_sets_r, l2_ways_r, l2_blk_r;

	// side 0 holds instruction lines, side 1 data lines
	logic        l1_valid [2][L1_LINES];
	logic [31:0] l1_tag   [2][L1_LINES];
	logic [2:0]  l1_old   [2][1 << L1_SET_BITS_MAX_D];
	logic        l2_valid [L2_LINES];
	logic [31:0] l2_tag   [L2_LINES];
	logic [2:0]  l2_old   [1 << L2_SET_BITS_MAX_D];

	outcome_t expected_outcomes[$];

	function automatic int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic outcome_t predict_access(mode_t m, logic [31:0] a);
		outcome_t o;
		int s1, b1, e1, s2, b2, e2, set1, set2, side, w, victim, base;
		logic [31:0] tag1, tag2;
		logic done_fill;
		s1 = clamp(l1_sets_r, 0, L1_SET_BITS_MAX_D);
		b1 = clamp(l1_blk_r, 0, BLOCK_BITS_TOP);
		e1 = clamp(l1_ways_r, 1, WAYS_MAX_D);
		s2 = clamp(l2_sets_r, 0, L2_SET_BITS_MAX_D);
		b2 = clamp(l2_blk_r, 0, BLOCK_BITS_TOP);
		e2 = clamp(l2_ways_r, 1, WAYS_MAX_D);
		set1 = (a >> b1) & ((1 << s1) - 1);
		tag1 = a >> (b1 + s1);
		set2 = (a >> b2) & ((1 << s2) - 1);
		tag2 = a >> (b2 + s2);
		side = (m == MODE_FETCH) ? 0 : 1;
		o = '0;
		for (w = 0; w < e1; w++)
			if (l1_valid[side][set1 * WAYS_MAX_D + w] && l1_tag[side][set1 * WAYS_MAX_D + w] == tag1)
				o.l1_hit = 1'b1;
		for (w = 0; w < e2; w++)
			if (l2_valid[set2 * WAYS_MAX_D + w] && l2_tag[set2 * WAYS_MAX_D + w] == tag2)
				o.l2_hit = 1'b1;
		if (m == MODE_STORE)
			return o;
		if (!o.l1_hit) begin
			base = set1 * WAYS_MAX_D;
			done_fill = 1'b0;
			for (w = 0; w < e1; w++)
				if (!done_fill && !l1_valid[side][base + w]) begin
					l1_valid[side][base + w] = 1'b1;
					l1_tag[side][base + w] = tag1;
					done_fill = 1'b1;
				end
			if (!done_fill) begin
				victim = l1_old[side][set1];
				if (victim >= e1) victim = 0;
				l1_tag[side][base + victim] = tag1;
				l1_old[side][set1] = (victim + 1 == e1) ? 0 : victim + 1;
				o.l1_evicted = 1'b1;
			end
		end
		if (!o.l2_hit) begin
			base = set2 * WAYS_MAX_D;
			done_fill = 1'b0;
			for (w = 0; w < e2; w++)
				if (!done_fill && !l2_valid[base + w]) begin
					l2_valid[base + w] = 1'b1;
					l2_tag[base + w] = tag2;
					done_fill = 1'b1;
				end
			if (!done_fill) begin
				victim = l2_old[set2];
				if (victim >= e2) victim = 0;
				l2_tag[base + victim] = tag2;
				l2_old[set2] = (victim + 1 == e2) ? 0 : victim + 1;
				o.l2_evicted = 1'b1;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		if (!arst_n) begin
			l1_sets_r = '0; l1_ways_r = 4'd1; l1_blk_r = '0;
			l2_sets_r = '0; l2_ways_r = 4'd1; l2_blk_r = '0;
			foreach (l1_valid[s, i]) l1_valid[s][i] = 1'b0;
			foreach (l1_old[s, i]) l1_old[s][i] = '0;
			foreach (l2_valid[i]) l2_valid[i] = 1'b0;
			foreach (l2_old[i]) l2_old[i] = '0;
			expected_outcomes.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					$error("result with no item outstanding");
					errors <= errors + 1;
				end else begin
					exp_o = expected_outcomes.pop_front();
					if (exp_o != {l1_hit, l2_hit, l1_evicted, l2_evicted}) begin
						errors <= errors + 1;
						if (exp_o.l1_hit != l1_hit)
							$error("l1_hit expected %0d got %0d", exp_o.l1_hit, l1_hit);
						if (exp_o.l2_hit != l2_hit)
							$error("l2_hit expected %0d got %0d", exp_o.l2_hit, l2_hit);
						if (exp_o.l1_evicted != l1_evicted)
							$error("l1_evicted expected %0d got %0d",
								exp_o.l1_evicted, l1_evicted);
						if (exp_o.l2_evicted != l2_evicted)
							$error("l2_evicted expected %0d got %0d",
								exp_o.l2_evicted, l2_evicted);
					end
				end
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_L1_SET_BITS:   l1_sets_r = cfg_data[2:0];
					REG_L1_WAYS:       l1_ways_r = cfg_data;
					REG_L1_BLOCK_BITS: l1_blk_r = cfg_data;
					REG_L2_SET_BITS:   l2_sets_r = cfg_data;
					REG_L2_WAYS:       l2_ways_r = cfg_data;
					REG_L2_BLOCK_BITS: l2_blk_r = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_outcomes.push_back(predict_access(mode_t'(mode), address));
			pending <= expected_outcomes.size();
		end
	end
endmodule

>>> sim/tb_two_level_cache_tag_engine.sv
module tb_two_level_cache_tag_engine;
	import tce_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_FETCH;
	logic [31:0] address = '0;
	logic        done, l1_hit, l2_hit, l1_evicted, l2_evicted;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_L1_SET_BITS;
	logic [3:0]  cfg_data = '0;
	logic        taken = 1'b0;
	int          pending, errors;
	int          cycles = 0;
	int          idle_pct = 0;
	logic [31:0] addr_pool[16];

	always #5 clk = ~clk;

	two_level_cache_tag_engine dut (.*);

	two_level_cache_tag_engine_checker checker_i (.*);

	always @(posedge clk) taken <= arst_n && start && !busy;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// hold the item until the block takes it; return at a falling edge
	task automatic send_item(mode_t m, logic [31:0] a);
		if (idle_pct > 0)
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start <= 1'b1;
		mode <= m;
		address <= a;
		do @(negedge clk); while (!taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic configure(logic [3:0] v[6]);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= v[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		if ($urandom_range(99) < 80)
			return addr_pool[$urandom_range(15)] ^ $urandom_range(3);
		return $urandom;
	endfunction

	initial begin
		logic [3:0] settings[6][6];
		int pct[4];
		settings = '{
			'{4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
			'{4'd0, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0},
			'{4'd7, 4'd0, 4'd15, 4'd15, 4'd0, 4'd15},
			'{4'd2, 4'd4, 4'd4, 4'd3, 4'd2, 4'd5},
			'{4'd3, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2},
			'{4'd1, 4'd2, 4'd9, 4'd2, 4'd3, 4'd0}};
		pct = '{0, 65, 0, 20};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: one L2 line and one line per L1 side, every address competes for them
		send_item(MODE_FETCH, 32'h0);
		send_item(MODE_FETCH, 32'h0);
		send_item(MODE_LOAD, 32'h0);
		send_item(MODE_STORE, 32'h0);
		send_item(MODE_STORE, 32'h1234_5678);
		send_item(MODE_MODIFY, 32'hFFFF_FFFF);
		send_item(MODE_LOAD, 32'hFFFF_FFFF);
		send_item(MODE_FETCH, 32'h8000_0000);
		send_item(MODE_MODIFY, 32'h0);
		send_item(MODE_STORE, 32'hFFFF_FFFF);
		drain();
		configure(settings[3]);
		// fill one set past its ways to reach FIFO eviction
		for (int i = 0; i < 12; i++)
			send_item(i % 3 == 0 ? MODE_FETCH : MODE_LOAD, (i % 7) << 16);
		drain();

		for (int p = 0; p < 12; p++) begin
			configure(settings[p % 6]);
			idle_pct = pct[p % 4];
			foreach (addr_pool[i]) addr_pool[i] = $urandom_range(0, 255) << $urandom_range(0, 14);
			for (int n = 0; n < 85; n++) begin
				send_item(mode_t'($urandom_range(0, 3)), pick_address());
				if (p == 5 && n == 40) begin
					start <= 1'b0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
